[rtl/aabb_mc_pkg.sv]
// ----------------------------------------------------------------------------
// aabb_mc_pkg
// types and codes shared by the box move-and-collide block
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_mc_pkg;

  localparam int unsigned SizeW  = 31;
  localparam int unsigned CoordW = 32;
  localparam int unsigned StepW  = 16;

  localparam logic [SizeW-1:0] BoxSizeReset = 31'd1048576;

  typedef enum logic [1:0] {
    MODE_LOAD_VEL = 2'd0,
    MODE_LOAD_POS = 2'd1,
    MODE_MOVE     = 2'd2,
    MODE_IGNORE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CONTACT_NONE       = 3'd0,
    CONTACT_UNRESOLVED = 3'd1,
    CONTACT_HORIZ      = 3'd2,
    CONTACT_VERT       = 3'd3,
    CONTACT_CORNER_Y   = 3'd4,
    CONTACT_CORNER_X   = 3'd5
  } contact_e;

  typedef enum logic {
    CFG_BOX_WIDTH  = 1'b0,
    CFG_BOX_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    mode_e                    mode;
    logic signed [CoordW-1:0] value_x;
    logic signed [CoordW-1:0] value_y;
    logic signed [CoordW-1:0] obstacle_x;
    logic signed [CoordW-1:0] obstacle_y;
    logic        [SizeW-1:0]  obstacle_w;
    logic        [SizeW-1:0]  obstacle_h;
    logic        [StepW-1:0]  time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] vel_x;
    logic signed [CoordW-1:0] vel_y;
  } box_state_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] vel_x;
    logic signed [CoordW-1:0] vel_y;
    contact_e                 contact;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/aabb_move_and_collide.sv]
// ----------------------------------------------------------------------------
// aabb_move_and_collide
// one moving box against one obstacle per item, Q16.16 fixed point
// ----------------------------------------------------------------------------
//  channel   signals                            payload
//  input     in_valid_i / in_stall_o            in_data_i  (in_item_t)
//  output    out_valid_o / out_stall_i          out_data_o (out_item_t)
//  config    cfg_we_i, cfg_idx_i, cfg_data_i    box width, box height
//
//  two-stage: input register, then one pass of logic into the result register
//  and the box state; one item per cycle while out_stall_i does not hold a result
//  the state feedback loop is the single state register, updated with the result
//  reset clears position and velocity, box size returns to 16.0
//  a stalled result holds one more item in the input register, then in_stall_o
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_move_and_collide
  import aabb_mc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  cfg_idx_e             cfg_idx_i,
  input  logic     [SizeW-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o
);

  logic             [SizeW-1:0] box_w_q, box_h_q;
  box_state_t                   state_q, state_d;
  in_item_t                     in_q;
  logic                         in_valid_q, in_valid_d;
  out_item_t                    out_q, out_d;
  logic                         out_valid_q, out_valid_d;
  contact_e                     contact;
  logic                         advance, in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_w_q <= BoxSizeReset;
      box_h_q <= BoxSizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BOX_WIDTH:  box_w_q <= cfg_data_i;
        CFG_BOX_HEIGHT: box_h_q <= cfg_data_i;
        default:        box_w_q <= box_w_q;
      endcase
    end
  end

  aabb_mc_step u_step (
    .item_i    (in_q),
    .state_i   (state_q),
    .box_w_i   (box_w_q),
    .box_h_i   (box_h_q),
    .state_o   (state_d),
    .contact_o (contact)
  );

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      in_valid_d  = 1'b0;
      out_valid_d = in_valid_q;
      out_d       = '{pos_x: state_d.pos_x, pos_y: state_d.pos_y,
                      vel_x: state_d.vel_x, vel_y: state_d.vel_y,
                      contact: contact};
    end
    if (in_take) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance && in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // an item waiting behind a stalled result is kept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |=> in_valid_q)
    else $error("waiting item dropped");

  // the shown result always matches the held box state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pos_x == state_q.pos_x) &&
                    (out_data_o.pos_y == state_q.pos_y) &&
                    (out_data_o.vel_x == state_q.vel_x) &&
                    (out_data_o.vel_y == state_q.vel_y))
    else $error("result and state disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.contact == CONTACT_HORIZ ||
                    out_data_o.contact == CONTACT_CORNER_X) |-> out_data_o.vel_x == '0)
    else $error("blocked x velocity not cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.contact == CONTACT_VERT ||
                    out_data_o.contact == CONTACT_CORNER_Y) |-> out_data_o.vel_y == '0)
    else $error("blocked y velocity not cleared");
`endif

endmodule

`default_nettype wire

[rtl/aabb_mc_step.sv]
// ----------------------------------------------------------------------------
// aabb_mc_step
// next box state and contact code for one item: loads, an ignored item, or a projected move
// tested against the obstacle and pushed back along the entry axis
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_mc_step
  import aabb_mc_pkg::*;
(
  input  in_item_t                 item_i,
  input  box_state_t               state_i,
  input  logic       [SizeW-1:0]   box_w_i,
  input  logic       [SizeW-1:0]   box_h_i,
  output box_state_t               state_o,
  output contact_e                 contact_o
);

  localparam int unsigned ProdW = CoordW + StepW + 1;
  localparam int unsigned ExtW  = CoordW + 2;

  logic signed [ProdW-1:0]  prod_x, prod_y, disp_x, disp_y;
  logic signed [CoordW-1:0] new_x, new_y;
  logic signed [ExtW-1:0]   old_xe, old_ye, new_xe, new_ye;
  logic signed [ExtW-1:0]   ob_x, ob_y, ob_w, ob_h, bw, bh;
  logic signed [ExtW-1:0]   ob_right, ob_bottom, push_left, push_up;
  logic                     hit;
  logic                     vx_pos, vx_neg, vy_pos, vy_neg;
  logic                     enter_x, enter_y;
  logic        [CoordW-1:0] res_x, res_y;
  logic        [CoordW:0]   mag_x, mag_y;

  // floor(vel * t / 2^16) from an arithmetic shift of the full product
  assign prod_x = ProdW'(state_i.vel_x) * ProdW'($signed({1'b0, item_i.time_step}));
  assign prod_y = ProdW'(state_i.vel_y) * ProdW'($signed({1'b0, item_i.time_step}));
  assign disp_x = prod_x >>> StepW;
  assign disp_y = prod_y >>> StepW;
  assign new_x  = state_i.pos_x + disp_x[CoordW-1:0];
  assign new_y  = state_i.pos_y + disp_y[CoordW-1:0];

  // edges in two extra bits so nothing wraps in the compares
  assign old_xe = {{2{state_i.pos_x[CoordW-1]}}, state_i.pos_x};
  assign old_ye = {{2{state_i.pos_y[CoordW-1]}}, state_i.pos_y};
  assign new_xe = {{2{new_x[CoordW-1]}}, new_x};
  assign new_ye = {{2{new_y[CoordW-1]}}, new_y};
  assign ob_x   = {{2{item_i.obstacle_x[CoordW-1]}}, item_i.obstacle_x};
  assign ob_y   = {{2{item_i.obstacle_y[CoordW-1]}}, item_i.obstacle_y};
  assign ob_w   = {3'b000, item_i.obstacle_w};
  assign ob_h   = {3'b000, item_i.obstacle_h};
  assign bw     = {3'b000, box_w_i};
  assign bh     = {3'b000, box_h_i};

  assign ob_right  = ob_x + ob_w;
  assign ob_bottom = ob_y + ob_h;
  assign push_left = ob_x - bw;
  assign push_up   = ob_y - bh;

  assign hit = (new_xe < ob_right) && (ob_x < new_xe + bw) &&
               (new_ye < ob_bottom) && (ob_y < new_ye + bh);

  assign vx_neg = state_i.vel_x[CoordW-1];
  assign vy_neg = state_i.vel_y[CoordW-1];
  assign vx_pos = !vx_neg && (state_i.vel_x != '0);
  assign vy_pos = !vy_neg && (state_i.vel_y != '0);

  // under a hit, an entry side always gives a nonzero penetration
  assign enter_x = (vx_pos && (old_xe + bw <= ob_x)) || (vx_neg && (old_xe >= ob_right));
  assign enter_y = (vy_pos && (old_ye + bh <= ob_y)) || (vy_neg && (old_ye >= ob_bottom));

  // pushed back flush against the entered face
  assign res_x = vx_pos ? push_left[CoordW-1:0] : ob_right[CoordW-1:0];
  assign res_y = vy_pos ? push_up[CoordW-1:0]   : ob_bottom[CoordW-1:0];

  assign mag_x = vx_neg ? ((CoordW+1)'(0) - {vx_neg, state_i.vel_x}) : {1'b0, state_i.vel_x};
  assign mag_y = vy_neg ? ((CoordW+1)'(0) - {vy_neg, state_i.vel_y}) : {1'b0, state_i.vel_y};

  always_comb begin
    state_o   = state_i;
    contact_o = CONTACT_NONE;
    unique case (item_i.mode)
      MODE_LOAD_VEL: begin
        state_o.vel_x = item_i.value_x;
        state_o.vel_y = item_i.value_y;
      end
      MODE_LOAD_POS: begin
        state_o.pos_x = item_i.value_x;
        state_o.pos_y = item_i.value_y;
      end
      MODE_MOVE: begin
        state_o.pos_x = new_x;
        state_o.pos_y = new_y;
        if (hit) begin
          priority if (enter_x && !enter_y) begin
            state_o.pos_x = res_x;
            state_o.vel_x = '0;
            contact_o     = CONTACT_HORIZ;
          end else if (!enter_x && enter_y) begin
            state_o.pos_y = res_y;
            state_o.vel_y = '0;
            contact_o     = CONTACT_VERT;
          end else if (enter_x && enter_y) begin
            // corner: resolve only the slower axis, x on a tie
            if (mag_x > mag_y) begin
              state_o.pos_y = res_y;
              state_o.vel_y = '0;
              contact_o     = CONTACT_CORNER_Y;
            end else begin
              state_o.pos_x = res_x;
              state_o.vel_x = '0;
              contact_o     = CONTACT_CORNER_X;
            end
          end else begin
            contact_o = CONTACT_UNRESOLVED;
          end
        end
      end
      MODE_IGNORE: begin
        state_o = state_i;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

`default_nettype wire
